### src/adc_scan_controller_top_macros.svh
// Assertion macros for the A/D scan controller checker.
`ifndef ADC_SCAN_CONTROLLER_TOP_MACROS_SVH
`define ADC_SCAN_CONTROLLER_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ADCSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ADCSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/adcsc_pkg.sv
// Types and constants shared by the A/D scan controller modules.
`default_nettype none

package adcsc_pkg;

    localparam int unsigned NUM_CHANNELS = 8;
    localparam int unsigned SAMPLE_BITS  = 10;
    localparam int unsigned NUM_LANES    = 4;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [3:0] REG_CONTROL = 4'd8;

    localparam logic CFG_TICK = 1'b0;
    localparam logic CFG_CONV = 1'b1;

    localparam logic [7:0]  TICK_RESET = 8'd12;
    localparam logic [15:0] CONV_RESET = 16'd200;

    localparam int unsigned CS_DONE_BIT  = 7;
    localparam int unsigned CS_IE_BIT    = 6;
    localparam int unsigned CS_START_BIT = 5;
    localparam int unsigned CS_SCAN_BIT  = 4;
    localparam int unsigned CS_BASE_BIT  = 2;

    typedef struct packed {
        logic [1:0]             func;
        logic [3:0]             reg_index;
        logic [7:0]             write_data;
        logic [SAMPLE_BITS-1:0] level_ch0;
        logic [SAMPLE_BITS-1:0] level_ch1;
        logic [SAMPLE_BITS-1:0] level_ch2;
        logic [SAMPLE_BITS-1:0] level_ch3;
        logic [SAMPLE_BITS-1:0] level_ch4;
        logic [SAMPLE_BITS-1:0] level_ch5;
        logic [SAMPLE_BITS-1:0] level_ch6;
        logic [SAMPLE_BITS-1:0] level_ch7;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
    } out_word_t;

    typedef logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] level_arr_t;

    typedef struct packed {
        logic                   wr;
        logic [SAMPLE_BITS-1:0] sample;
    } lane_res_t;

    typedef lane_res_t [NUM_LANES-1:0] lane_arr_t;

endpackage

`default_nettype wire

### src/adcsc_lane.sv
// One conversion lane: picks the channel for its result pair and flags a store.
`default_nettype none

module adcsc_lane (
    input  logic                  fire,
    input  logic [7:0]            ctrl,
    input  logic [1:0]            lane_idx,
    input  adcsc_pkg::level_arr_t levels,
    output adcsc_pkg::lane_res_t  res
);
    import adcsc_pkg::*;

    logic [2:0] channel;
    logic       hit;

    // pair index equals channel mod 4, so the lane index is the low channel bits
    assign channel = {ctrl[CS_BASE_BIT], lane_idx};

    always_comb begin
        if (ctrl[CS_SCAN_BIT]) begin
            hit = (lane_idx <= ctrl[1:0]);
        end else begin
            hit = (lane_idx == ctrl[1:0]);
        end
    end

    assign res.wr     = fire && hit;
    assign res.sample = levels[channel];

endmodule

`default_nettype wire

### src/adcsc_result_bank.sv
// Result pairs: merges lane stores and serves byte reads.
`default_nettype none

module adcsc_result_bank (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  adcsc_pkg::lane_arr_t lane_res,
    input  logic [2:0]           rd_index,
    output logic [7:0]           rd_byte
);
    import adcsc_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_reg [NUM_LANES];
    logic [SAMPLE_BITS-1:0] sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                sample_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if (lane_res[i].wr) begin
                    sample_reg[i] <= lane_res[i].sample;
                end
            end
        end
    end

    // high byte holds bits 9:2, low byte bits 1:0 in 7:6
    assign sel     = sample_reg[rd_index[2:1]];
    assign rd_byte = rd_index[0] ? {sel[1:0], 6'b0} : sel[SAMPLE_BITS-1:2];

endmodule

`default_nettype wire

### src/adc_scan_controller_top.sv
// Top level of the A/D scan controller: control, timing, lanes and bus side.
//
//   port group | direction | word
//   s_*        | in        | tick with 8 channel levels, register read or write
//   m_*        | out       | read byte and interrupt level, one per input word
//   apb        | in/out    | tick_cycles (0x0), conversion_cycles (0x4)
//
// A tick goes from acceptance through ST_ADV, for the 64-bit time add, and ST_CONV,
// for the finish-time compare, then through ST_RESP before s_ready returns. A
// register read or write goes from ST_IDLE to ST_RESP. One word is in flight at a time;
// a waiting result stalls only the response step. Reset is synchronous and clears
// all state but the input and output word registers, result registers included.
`default_nettype none

module adc_scan_controller_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  adcsc_pkg::in_word_t  s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output adcsc_pkg::out_word_t m_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import adcsc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADV  = 4'b0010,
        ST_CONV = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    in_word_t   item_reg;
    logic [7:0]  tick_reg;
    logic [15:0] conv_reg;
    logic [7:0]  cs_reg, cs_next;
    logic        done_seen_reg, done_seen_next;
    logic        irq_reg, irq_next;
    logic [63:0] time_reg, time_next;
    logic [63:0] finish_reg, finish_next;
    logic        m_valid_reg, m_valid_next;
    out_word_t   m_word_reg, m_word_next;

    logic        cfg_wr;
    logic        fire;
    logic        due;
    logic [63:0] fin_sched;
    level_arr_t  levels;
    lane_arr_t   lane_res;
    logic [7:0]  bank_rd;
    logic [7:0]  rd;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {16'b0, conv_reg} : {24'b0, tick_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_RESET;
            conv_reg <= CONV_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_TICK: tick_reg <= pwdata[7:0];
                CFG_CONV: conv_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign levels[0] = item_reg.level_ch0;
    assign levels[1] = item_reg.level_ch1;
    assign levels[2] = item_reg.level_ch2;
    assign levels[3] = item_reg.level_ch3;
    assign levels[4] = item_reg.level_ch4;
    assign levels[5] = item_reg.level_ch5;
    assign levels[6] = item_reg.level_ch6;
    assign levels[7] = item_reg.level_ch7;

    assign due       = (finish_reg != 64'd0) && (finish_reg < time_reg);
    assign fin_sched = time_reg + {48'b0, conv_reg};
    assign fire      = (state_reg == ST_CONV) && cs_reg[CS_START_BIT] && due;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        adcsc_lane u_lane (
            .fire     (fire),
            .ctrl     (cs_reg),
            .lane_idx (2'(g)),
            .levels   (levels),
            .res      (lane_res[g])
        );
    end

    adcsc_result_bank u_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_res (lane_res),
        .rd_index (item_reg.reg_index[2:0]),
        .rd_byte  (bank_rd)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cs_next        = cs_reg;
        done_seen_next = done_seen_reg;
        irq_next       = irq_reg;
        time_next      = time_reg;
        finish_next    = finish_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        rd             = 8'd0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_word.func == FUNC_TICK) ? ST_ADV : ST_RESP;
                end
            end
            ST_ADV: begin
                time_next  = time_reg + {56'b0, tick_reg};
                state_next = ST_CONV;
            end
            ST_CONV: begin
                if (!cs_reg[CS_START_BIT]) begin
                    finish_next = 64'd0;
                end else if (finish_reg == 64'd0) begin
                    finish_next = fin_sched;
                end else if (due) begin
                    if (cs_reg[CS_SCAN_BIT]) begin
                        finish_next = fin_sched;
                    end else begin
                        cs_next[CS_START_BIT] = 1'b0;
                        finish_next           = 64'd0;
                    end
                    cs_next[CS_DONE_BIT] = 1'b1;
                    if (cs_reg[CS_IE_BIT]) begin
                        irq_next = 1'b1;
                    end
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    case (item_reg.func)
                        FUNC_READ: begin
                            if (!item_reg.reg_index[3]) begin
                                rd = bank_rd;
                            end else if (item_reg.reg_index == REG_CONTROL) begin
                                done_seen_next = cs_reg[CS_DONE_BIT];
                                rd             = cs_reg;
                            end
                        end
                        FUNC_WRITE: begin
                            if (item_reg.reg_index == REG_CONTROL) begin
                                cs_next = {cs_reg[CS_DONE_BIT], item_reg.write_data[6:0]};
                                // done clears only after a read saw it set
                                if (!item_reg.write_data[CS_DONE_BIT] && done_seen_reg) begin
                                    cs_next[CS_DONE_BIT] = 1'b0;
                                    irq_next             = 1'b0;
                                end
                                if (!item_reg.write_data[CS_IE_BIT]) begin
                                    irq_next = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                    m_valid_next          = 1'b1;
                    m_word_next.read_data = rd;
                    m_word_next.irq_level = irq_next;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cs_reg        <= 8'd0;
            done_seen_reg <= 1'b0;
            irq_reg       <= 1'b0;
            time_reg      <= 64'd0;
            finish_reg    <= 64'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cs_reg        <= cs_next;
            done_seen_reg <= done_seen_next;
            irq_reg       <= irq_next;
            time_reg      <= time_next;
            finish_reg    <= finish_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        if (s_valid && s_ready) begin
            item_reg <= s_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

`default_nettype wire

### src/adcsc_checker.sv
// Port-level checks for the A/D scan controller, bound to the top level.
`default_nettype none

`include "adc_scan_controller_top_macros.svh"

module adcsc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input adcsc_pkg::out_word_t m_word
);

    `ADCSC_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid && $stable(m_word), "result word changed while stalled")
    `ADCSC_ASSERT(a_one_word, s_valid && s_ready |=> !s_ready, "second word taken while one is in flight")
    `ADCSC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

endmodule

bind adc_scan_controller_top adcsc_checker u_adcsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the A/D scan controller: predictor, stimulus and word checks.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adcsc_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [3:0] RES_A_HI     = 4'd0;
    localparam logic [3:0] RES_A_LO     = 4'd1;
    localparam logic [3:0] RES_B_HI     = 4'd2;
    localparam logic [3:0] RES_B_LO     = 4'd3;
    localparam logic [3:0] RES_D_LO     = 4'd7;
    localparam logic [3:0] REG_UNMAP_LO = 4'd9;
    localparam logic [3:0] REG_UNMAP_HI = 4'd15;

    localparam logic [2:0] ADDR_TICK = 3'd0;
    localparam logic [2:0] ADDR_CONV = 3'd4;

    localparam logic [7:0] CS_DONE  = 8'h01 << CS_DONE_BIT;
    localparam logic [7:0] CS_IE    = 8'h01 << CS_IE_BIT;
    localparam logic [7:0] CS_START = 8'h01 << CS_START_BIT;
    localparam logic [7:0] CS_SCAN  = 8'h01 << CS_SCAN_BIT;
    localparam logic [7:0] CS_BASE  = 8'h01 << CS_BASE_BIT;

    localparam int unsigned IDLE_PCT    = 34;
    localparam int unsigned CALM_FIRST  = 600;
    localparam int unsigned CALM_LAST   = 800;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_WORDS = 230;
    localparam int unsigned TAIL_CYCLES = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    adc_scan_controller_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state
    logic [7:0]  tick_cfg;
    logic [15:0] conv_cfg;
    logic [7:0]  ctrl_m;
    logic [7:0]  result_m [8];
    bit          done_seen_m;
    logic [63:0] now_m;
    logic [63:0] finish_m;
    bit          irq_m;

    out_word_t   expected_q [$];
    in_word_t    stim_q [$];

    typedef struct {
        in_word_t    w;
        int unsigned reps;
        bit          zero_res;   // reads zero with no interrupt, typed in
    } dir_row_t;

    dir_row_t    directed_rows [$];

    int unsigned words_sent;
    int unsigned words_by_func [4];
    int unsigned results_checked;
    int unsigned conversions_done;
    int unsigned settings_used;
    int unsigned mismatches;

    task automatic reset_model();
        tick_cfg    = TICK_RESET;
        conv_cfg    = CONV_RESET;
        ctrl_m      = '0;
        foreach (result_m[i]) result_m[i] = '0;
        done_seen_m = 1'b0;
        now_m       = '0;
        finish_m    = '0;
        irq_m       = 1'b0;
    endtask

    function automatic void store_level(int ch, logic [SAMPLE_BITS-1:0] lvl);
        result_m[(ch % 4) * 2]     = lvl[9:2];
        result_m[(ch % 4) * 2 + 1] = {lvl[1:0], 6'b0};
    endfunction

    function automatic out_word_t predict_result(in_word_t w);
        logic [SAMPLE_BITS-1:0] lv [NUM_CHANNELS];
        logic [7:0]             ctrl;
        out_word_t              r;
        lv[0] = w.level_ch0;
        lv[1] = w.level_ch1;
        lv[2] = w.level_ch2;
        lv[3] = w.level_ch3;
        lv[4] = w.level_ch4;
        lv[5] = w.level_ch5;
        lv[6] = w.level_ch6;
        lv[7] = w.level_ch7;
        r.read_data = '0;
        case (w.func)
            FUNC_TICK: begin
                now_m = now_m + tick_cfg;
                ctrl  = ctrl_m;
                if (!ctrl[CS_START_BIT]) begin
                    finish_m = '0;
                end else if (finish_m == 0) begin
                    finish_m = now_m + conv_cfg;
                end else if (finish_m < now_m) begin
                    if (ctrl[CS_SCAN_BIT]) begin
                        // group base is channel 0 or 4, offsets up to 3
                        for (int i = 0; i <= ctrl[1:0]; i++)
                            store_level((ctrl[CS_BASE_BIT] ? 4 : 0) + i,
                                        lv[(ctrl[CS_BASE_BIT] ? 4 : 0) + i]);
                        finish_m = now_m + conv_cfg;
                    end else begin
                        store_level(int'(ctrl[2:0]), lv[ctrl[2:0]]);
                        ctrl_m[CS_START_BIT] = 1'b0;
                        finish_m = '0;
                    end
                    ctrl_m[CS_DONE_BIT] = 1'b1;
                    if (ctrl[CS_IE_BIT]) irq_m = 1'b1;
                    conversions_done++;
                end
            end
            FUNC_READ: begin
                if (w.reg_index < REG_CONTROL) begin
                    r.read_data = result_m[w.reg_index[2:0]];
                end else if (w.reg_index == REG_CONTROL) begin
                    done_seen_m = ctrl_m[CS_DONE_BIT];
                    r.read_data = ctrl_m;
                end
            end
            FUNC_WRITE: begin
                if (w.reg_index == REG_CONTROL) begin
                    ctrl_m = {ctrl_m[CS_DONE_BIT], w.write_data[6:0]};
                    // done only clears once a status read has seen it
                    if (!w.write_data[CS_DONE_BIT] && done_seen_m) begin
                        ctrl_m[CS_DONE_BIT] = 1'b0;
                        irq_m = 1'b0;
                    end
                    if (!w.write_data[CS_IE_BIT]) irq_m = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.irq_level = irq_m;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return 10'($urandom_range(1023));
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        w.func       = 2'($urandom_range(3));
        w.reg_index  = 4'($urandom_range(15));
        w.write_data = 8'($urandom_range(255));
        w.level_ch0  = rand_level();
        w.level_ch1  = rand_level();
        w.level_ch2  = rand_level();
        w.level_ch3  = rand_level();
        w.level_ch4  = rand_level();
        w.level_ch5  = rand_level();
        w.level_ch6  = rand_level();
        w.level_ch7  = rand_level();
        return w;
    endfunction

    function automatic void add_row(logic [1:0] f, logic [3:0] r, logic [7:0] d,
                                    logic [9:0] lvl, logic [9:0] step,
                                    int unsigned reps, bit zero_res);
        dir_row_t row;
        row.w.func       = f;
        row.w.reg_index  = r;
        row.w.write_data = d;
        row.w.level_ch0  = lvl;
        row.w.level_ch1  = lvl + step;
        row.w.level_ch2  = 10'(lvl + 2 * step);
        row.w.level_ch3  = 10'(lvl + 3 * step);
        row.w.level_ch4  = 10'(lvl + 4 * step);
        row.w.level_ch5  = 10'(lvl + 5 * step);
        row.w.level_ch6  = 10'(lvl + 6 * step);
        row.w.level_ch7  = 10'(lvl + 7 * step);
        row.reps         = reps;
        row.zero_res     = zero_res;
        directed_rows.push_back(row);
    endfunction

    // Register port: setup then access; psel is lowered by the caller after the last access
    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
    endtask

    task automatic set_config(input logic [7:0] tick_val, input logic [15:0] conv_val);
        logic [31:0] cfg_val [2];
        logic [31:0] rd;
        cfg_val[0] = {24'd0, tick_val};
        cfg_val[1] = {16'd0, conv_val};
        apb_access(1'b1, ADDR_TICK, cfg_val[0], rd);
        apb_access(1'b1, ADDR_CONV, cfg_val[1], rd);
        for (int i = 0; i < 2; i++) begin
            apb_access(1'b0, (i == 0) ? ADDR_TICK : ADDR_CONV, '0, rd);
            if (rd !== cfg_val[i]) begin
                mismatches++;
                $display("%0t: register %0d readback, expected %08h, got %08h",
                         $time, i, cfg_val[i], rd);
            end
        end
        psel     <= 1'b0;
        penable  <= 1'b0;
        tick_cfg  = tick_val;
        conv_cfg  = conv_val;
        settings_used++;
    endtask

    task automatic send_word(input in_word_t w, input bit zero_res);
        out_word_t res;
        bit        calm;
        calm = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        res = predict_result(w);
        expected_q.push_back(zero_res ? out_word_t'('0) : res);
        words_sent++;
        words_by_func[w.func]++;
    endtask

    task automatic wait_for_results();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Mostly arm-convert-read-acknowledge sequences with random content, some noise
    task automatic queue_sequence();
        in_word_t    w;
        int unsigned span;
        if ($urandom_range(99) < 75) begin
            w = rand_word();
            w.func      = FUNC_WRITE;
            w.reg_index = REG_CONTROL;
            w.write_data[CS_START_BIT] = ($urandom_range(9) != 0);
            stim_q.push_back(w);
            span = conv_cfg / tick_cfg + 3;
            if (span > 300) span = 300;
            repeat ($urandom_range(span / 2 + 1, span)) begin
                w = rand_word();
                w.func = FUNC_TICK;
                stim_q.push_back(w);
            end
            w = rand_word();
            w.func      = FUNC_READ;
            w.reg_index = REG_CONTROL;
            stim_q.push_back(w);
            repeat ($urandom_range(1, 3)) begin
                w = rand_word();
                w.func      = FUNC_READ;
                w.reg_index = 4'($urandom_range(RES_A_HI, RES_D_LO));
                stim_q.push_back(w);
            end
            if ($urandom_range(99) < 60) begin
                w = rand_word();
                w.func      = FUNC_WRITE;
                w.reg_index = REG_CONTROL;
                w.write_data[CS_DONE_BIT] = 1'b0;
                stim_q.push_back(w);
            end
        end else begin
            repeat ($urandom_range(1, 4)) stim_q.push_back(rand_word());
        end
    endtask

    task automatic run_phase(input logic [7:0] tick_val, input logic [15:0] conv_val);
        set_config(tick_val, conv_val);
        while (stim_q.size() < PHASE_WORDS) queue_sequence();
        // keep every phase the same length
        while (stim_q.size() > PHASE_WORDS) void'(stim_q.pop_back());
        while (stim_q.size() != 0) send_word(stim_q.pop_front(), 1'b0);
        s_valid <= 1'b0;
        wait_for_results();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset register values
        add_row(FUNC_READ,  REG_CONTROL,  8'h00, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_READ,  RES_A_HI,     8'h00, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_READ,  REG_UNMAP_HI, 8'h00, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_NONE,  REG_CONTROL,  8'hff, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_WRITE, RES_A_LO,     8'hff, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_WRITE, REG_UNMAP_LO, 8'hff, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_READ,  RES_A_LO,     8'h00, 10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_WRITE, REG_CONTROL,  CS_IE | CS_START | 8'd5,
                10'd0, 10'd0, 1, 1'b1);
        add_row(FUNC_TICK,  RES_A_HI,     8'h00, 10'h3ff, 10'd0, 1, 1'b1);
        add_row(FUNC_TICK,  RES_A_HI,     8'h00, 10'h3ff, 10'd0, 18, 1'b0);
        add_row(FUNC_READ,  RES_B_HI,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_READ,  RES_B_LO,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        // acknowledge before any status read: done must stay set
        add_row(FUNC_WRITE, REG_CONTROL,  8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_READ,  REG_CONTROL,  8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_WRITE, REG_CONTROL,  CS_DONE | CS_IE, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_WRITE, REG_CONTROL,  CS_IE | CS_START | CS_SCAN | CS_BASE | 8'd3,
                10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_TICK,  RES_A_HI,     8'h00, 10'd0, 10'd0, 20, 1'b0);
        add_row(FUNC_READ,  RES_A_HI,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_READ,  REG_CONTROL,  8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_WRITE, REG_CONTROL,  CS_START | CS_SCAN, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_TICK,  RES_A_HI,     8'h00, 10'h155, 10'h0a3, 40, 1'b0);
        add_row(FUNC_READ,  RES_A_HI,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_READ,  RES_A_LO,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_WRITE, REG_CONTROL,  8'h00, 10'd0, 10'd0, 1, 1'b0);
        add_row(FUNC_TICK,  RES_A_HI,     8'h00, 10'd0, 10'd0, 1, 1'b0);
        foreach (directed_rows[i])
            repeat (directed_rows[i].reps) send_word(directed_rows[i].w, directed_rows[i].zero_res);
        s_valid <= 1'b0;
        wait_for_results();

        run_phase(8'd1, 16'd1);
        run_phase(8'd255, 16'd65535);
        run_phase(8'($urandom_range(8, 255)), 16'($urandom_range(1, 1000)));
        run_phase(8'd255, 16'd1);
        run_phase(8'($urandom_range(1, 32)), 16'($urandom_range(1, 200)));

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d words: %0d ticks, %0d reads, %0d writes, %0d unused codes.",
                 words_sent, words_by_func[FUNC_TICK], words_by_func[FUNC_READ],
                 words_by_func[FUNC_WRITE], words_by_func[FUNC_NONE]);
        $display("%0d results checked, %0d conversions completed over %0d register settings.",
                 results_checked, conversions_done, settings_used);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: check each accepted word, throttle m_ready
    initial begin
        out_word_t   got;
        out_word_t   want;
        int unsigned hold_left;
        bit          held;
        bit          calm;
        m_ready  <= 1'b0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = m_word;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got read_data %02h irq %0b",
                             $time, got.read_data, got.irq_level);
                end else begin
                    want = expected_q.pop_front();
                    if (got.read_data !== want.read_data) begin
                        mismatches++;
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want.read_data, got.read_data);
                    end
                    if (got.irq_level !== want.irq_level) begin
                        mismatches++;
                        $display("%0t: irq_level mismatch, expected %0b, got %0b",
                                 $time, want.irq_level, got.irq_level);
                    end
                end
                results_checked++;
                if (results_checked == HOLD_AT && !held) begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            calm = (results_checked >= CALM_FIRST) && (results_checked < CALM_LAST);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
